@@ hdl/mlfq_pkg.sv @@
// Package for the three-level feedback-queue scheduler.
// Sizes, status and register codes, beat and queue-control types.
// No dependencies.
package mlfq_pkg;

  localparam int MAX_JOBS = 16;
  localparam int SLOT_W   = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int LEVELS   = 3;
  localparam int LVL_W    = 2;
  localparam int QNT_W    = 8;
  localparam int ID_W     = 8;
  localparam int BURST_W  = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int REGIDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJ_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJ_BAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RAN      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
  localparam logic [LVL_W-1:0] LVL_BOT = 2'd2;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  localparam logic [REGIDX_W-1:0] REG_QUANTUM0 = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_QUANTUM1 = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_QUANTUM2 = 2'd2;

  localparam logic [QNT_W-1:0] QUANTUM0_RST = 8'd2;
  localparam logic [QNT_W-1:0] QUANTUM1_RST = 8'd4;
  localparam logic [QNT_W-1:0] QUANTUM2_RST = 8'd8;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst_length;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     ran_id;
    logic [LVL_W-1:0]    ran_level;
    logic                job_finished;
    logic [TIME_W-1:0]   tick_time;
  } out_beat_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    slot_t push_slot;
  } q_ctrl_t;

  typedef struct packed {
    logic             nonempty;
    slot_t            head_slot;
    logic [CNT_W-1:0] count;
  } q_stat_t;

endpackage

@@ hdl/mlfq_queue.sv @@
// One level's ring of slot numbers: push at tail, pop at head, same cycle allowed.
// Depends on mlfq_pkg.
module mlfq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mlfq_pkg::q_ctrl_t ctrl,
  output mlfq_pkg::q_stat_t stat
);

  localparam int SUM_W = mlfq_pkg::CNT_W + 1;

  mlfq_pkg::slot_t                entries_r [mlfq_pkg::MAX_JOBS];
  mlfq_pkg::slot_t                head_r;
  mlfq_pkg::slot_t                head_nxt;
  logic [mlfq_pkg::CNT_W-1:0]     count_r;
  logic [mlfq_pkg::CNT_W-1:0]     count_nxt;
  logic [SUM_W-1:0]               tail_sum;
  mlfq_pkg::slot_t                tail;

  // tail position from pre-pop head/count: also right when popping the same cycle
  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(mlfq_pkg::MAX_JOBS)) begin
      tail_sum = tail_sum - SUM_W'(mlfq_pkg::MAX_JOBS);
    end
    tail = tail_sum[mlfq_pkg::SLOT_W-1:0];

    head_nxt = head_r;
    if (ctrl.pop) begin
      head_nxt = (head_r == mlfq_pkg::SLOT_W'(mlfq_pkg::MAX_JOBS - 1)) ?
                 '0 : head_r + mlfq_pkg::SLOT_W'(1);
    end

    case ({ctrl.push, ctrl.pop})
      2'b10:   count_nxt = count_r + mlfq_pkg::CNT_W'(1);
      2'b01:   count_nxt = count_r - mlfq_pkg::CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries_r[tail] <= ctrl.push_slot;
    end
  end

  assign stat.nonempty  = (count_r != '0);
  assign stat.head_slot = entries_r[head_r];
  assign stat.count     = count_r;

endmodule

@@ hdl/mlfq_tick_scheduler.sv @@
// Three-level feedback-queue scheduler, top level.
// Beats pass the input register, then the output register. One beat per cycle
// while out_stall is low; the slot/queue update is one registered pass.
// Reset (rst_n low, synchronous): no jobs, queues empty, nothing running,
// time zero, quanta 2/4/8. Slot payload stores are not cleared.
// Depends on mlfq_pkg and mlfq_queue.
module mlfq_tick_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mlfq_pkg::in_beat_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output mlfq_pkg::out_beat_t            out_data,
  // APB-style register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mlfq_pkg::ADDR_W-1:0]    paddr,
  input  logic [mlfq_pkg::DATA_W-1:0]    pwdata,
  output logic [mlfq_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mlfq_pkg::QNT_W-1:0]    quantum0_r, quantum1_r, quantum2_r;
  logic                          cfg_wr;
  logic [mlfq_pkg::REGIDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[mlfq_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum0_r <= mlfq_pkg::QUANTUM0_RST;
      quantum1_r <= mlfq_pkg::QUANTUM1_RST;
      quantum2_r <= mlfq_pkg::QUANTUM2_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mlfq_pkg::REG_QUANTUM0: quantum0_r <= pwdata[mlfq_pkg::QNT_W-1:0];
        mlfq_pkg::REG_QUANTUM1: quantum1_r <= pwdata[mlfq_pkg::QNT_W-1:0];
        mlfq_pkg::REG_QUANTUM2: quantum2_r <= pwdata[mlfq_pkg::QNT_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mlfq_pkg::REG_QUANTUM0: prdata = mlfq_pkg::DATA_W'(quantum0_r);
      mlfq_pkg::REG_QUANTUM1: prdata = mlfq_pkg::DATA_W'(quantum1_r);
      mlfq_pkg::REG_QUANTUM2: prdata = mlfq_pkg::DATA_W'(quantum2_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and output register. The result register parts the two
  // sides: a new beat moves in while the old result still waits on out_stall.
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r, s1_valid_nxt;
  mlfq_pkg::in_beat_t   s1_data_r;
  logic                 in_fire;
  logic                 adv;            // stage-1 beat is processed this cycle
  logic                 out_valid_r, out_valid_nxt;
  mlfq_pkg::out_beat_t  out_data_r;
  mlfq_pkg::out_beat_t  res;

  assign adv          = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !adv;
  assign in_fire      = in_valid && !in_stall;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Slot stores, running-job state and the three level queues
  // ---------------------------------------------------------------------------
  logic [mlfq_pkg::BURST_W-1:0] rem_r    [mlfq_pkg::MAX_JOBS];
  logic [mlfq_pkg::ID_W-1:0]    job_id_r [mlfq_pkg::MAX_JOBS];
  logic [mlfq_pkg::MAX_JOBS-1:0] busy_r, busy_nxt;

  mlfq_pkg::slot_t              running_slot_r, running_slot_nxt;
  logic                         running_valid_r, running_valid_nxt;
  logic [mlfq_pkg::LVL_W-1:0]   running_level_r, running_level_nxt;
  logic [mlfq_pkg::QNT_W-1:0]   slice_used_r, slice_used_nxt;
  logic [mlfq_pkg::TIME_W-1:0]  time_now_r, time_now_nxt;

  mlfq_pkg::q_ctrl_t q_ctrl [mlfq_pkg::LEVELS];
  mlfq_pkg::q_stat_t q_stat [mlfq_pkg::LEVELS];

  for (genvar g = 0; g < mlfq_pkg::LEVELS; g++) begin : g_level
    mlfq_queue u_queue (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (q_ctrl[g]),
      .stat  (q_stat[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Single-pass update for the beat in stage 1
  // ---------------------------------------------------------------------------
  logic                         is_tick;
  logic                         bad_arrival;
  logic                         free_found;
  mlfq_pkg::slot_t              free_slot;
  logic                         arrival_ok;
  logic                         sel_found;
  logic [mlfq_pkg::LVL_W-1:0]   sel_lvl;
  logic                         popping;
  logic                         cur_valid;
  mlfq_pkg::slot_t              cur_slot;
  logic [mlfq_pkg::LVL_W-1:0]   cur_lvl;
  logic [mlfq_pkg::BURST_W-1:0] rem_cur, rem_dec;
  logic [mlfq_pkg::QNT_W-1:0]   slice_inc;
  logic [mlfq_pkg::QNT_W-1:0]   q_eff;
  logic                         fin;
  logic                         demote;
  logic [mlfq_pkg::LVL_W-1:0]   next_lvl;
  logic                         run_go;
  logic                         rem_we;
  mlfq_pkg::slot_t              rem_wa;
  logic [mlfq_pkg::BURST_W-1:0] rem_wd;

  always_comb begin
    is_tick     = (s1_data_r.kind == mlfq_pkg::KIND_TICK);
    bad_arrival = (s1_data_r.job_id == '0) || (s1_data_r.burst_length == '0);

    // lowest free slot wins
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = mlfq_pkg::MAX_JOBS - 1; s >= 0; s--) begin
      if (!busy_r[s]) begin
        free_found = 1'b1;
        free_slot  = mlfq_pkg::SLOT_W'(s);
      end
    end
    arrival_ok = adv && !is_tick && !bad_arrival && free_found;

    // highest-priority non-empty level
    sel_found = 1'b0;
    sel_lvl   = mlfq_pkg::LVL_TOP;
    for (int l = mlfq_pkg::LEVELS - 1; l >= 0; l--) begin
      if (q_stat[l].nonempty) begin
        sel_found = 1'b1;
        sel_lvl   = mlfq_pkg::LVL_W'(l);
      end
    end

    popping   = !running_valid_r && sel_found;
    cur_valid = running_valid_r || sel_found;
    cur_slot  = running_valid_r ? running_slot_r  : q_stat[sel_lvl].head_slot;
    cur_lvl   = running_valid_r ? running_level_r : sel_lvl;

    rem_cur   = rem_r[cur_slot];
    rem_dec   = (rem_cur != '0) ? rem_cur - mlfq_pkg::BURST_W'(1) : '0;
    slice_inc = (running_valid_r ? slice_used_r : '0) + mlfq_pkg::QNT_W'(1);

    case (cur_lvl)
      mlfq_pkg::LVL_TOP: q_eff = quantum0_r;
      mlfq_pkg::LVL_MID: q_eff = quantum1_r;
      default:           q_eff = quantum2_r;
    endcase
    if (q_eff == '0) begin
      q_eff = mlfq_pkg::QNT_W'(1);  // zero quantum behaves as one
    end

    fin      = (rem_dec == '0);
    demote   = !fin && (slice_inc >= q_eff);
    next_lvl = (cur_lvl == mlfq_pkg::LVL_BOT) ? mlfq_pkg::LVL_BOT
                                               : cur_lvl + mlfq_pkg::LVL_W'(1);
    run_go   = adv && is_tick && cur_valid;

    // queue controls
    for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
      q_ctrl[l].pop  = adv && is_tick && popping && (sel_lvl == mlfq_pkg::LVL_W'(l));
      q_ctrl[l].push = (arrival_ok && (l == 0)) ||
                       (run_go && demote && (next_lvl == mlfq_pkg::LVL_W'(l)));
      q_ctrl[l].push_slot = arrival_ok ? free_slot : cur_slot;
    end

    // defaults: hold
    busy_nxt          = busy_r;
    running_slot_nxt  = running_slot_r;
    running_valid_nxt = running_valid_r;
    running_level_nxt = running_level_r;
    slice_used_nxt    = slice_used_r;
    time_now_nxt      = time_now_r;
    rem_we            = 1'b0;
    rem_wa            = free_slot;
    rem_wd            = s1_data_r.burst_length;

    res              = '0;
    res.tick_time    = time_now_r;

    if (adv) begin
      if (!is_tick) begin
        if (bad_arrival) begin
          res.status = mlfq_pkg::ST_REJ_BAD;
        end else if (!free_found) begin
          res.status = mlfq_pkg::ST_REJ_FULL;
        end else begin
          res.status          = mlfq_pkg::ST_ACCEPTED;
          busy_nxt[free_slot] = 1'b1;
          rem_we              = 1'b1;
        end
      end else begin
        time_now_nxt  = time_now_r + mlfq_pkg::TIME_W'(1);
        res.tick_time = time_now_nxt;
        if (!cur_valid) begin
          res.status = mlfq_pkg::ST_IDLE;
        end else begin
          res.status        = mlfq_pkg::ST_RAN;
          res.ran_id        = job_id_r[cur_slot];
          res.ran_level     = cur_lvl;
          res.job_finished  = fin;
          rem_we            = 1'b1;
          rem_wa            = cur_slot;
          rem_wd            = rem_dec;
          slice_used_nxt    = slice_inc;
          running_slot_nxt  = cur_slot;
          running_level_nxt = cur_lvl;
          running_valid_nxt = !(fin || demote);
          if (fin) begin
            busy_nxt[cur_slot] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= '0;
      running_slot_r  <= '0;
      running_valid_r <= 1'b0;
      running_level_r <= mlfq_pkg::LVL_TOP;
      slice_used_r    <= '0;
      time_now_r      <= '0;
    end else begin
      busy_r          <= busy_nxt;
      running_slot_r  <= running_slot_nxt;
      running_valid_r <= running_valid_nxt;
      running_level_r <= running_level_nxt;
      slice_used_r    <= slice_used_nxt;
      time_now_r      <= time_now_nxt;
    end
  end

  // slot payload: no reset, only busy slots are ever read
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_r[rem_wa] <= rem_wd;
    end
    if (arrival_ok) begin
      job_id_r[free_slot] <= s1_data_r.job_id;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the running job always owns a busy slot
  a_running_busy: assert property (@(posedge clk) disable iff (!rst_n)
    running_valid_r |-> busy_r[running_slot_r])
    else $error("running job has no busy slot");

  // queued plus running jobs never exceed busy slots
  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(q_stat[0].count) + int'(q_stat[1].count) + int'(q_stat[2].count) +
     int'(running_valid_r)) <= $countones(busy_r))
    else $error("queues hold more jobs than busy slots");

  // a processed tick advances time by exactly one
  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_tick) |=> (time_now_r == $past(time_now_r) + mlfq_pkg::TIME_W'(1)))
    else $error("tick did not advance time");

  // a result that finishes a job always comes from a tick that ran it
  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.job_finished) |-> (res.status == mlfq_pkg::ST_RAN))
    else $error("finish flagged without a run");

endmodule

@@ bench/mlfq_tick_scheduler_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mlfq_tick_scheduler: random and directed arrival/tick beats,
// scheduler prediction, field-by-field result check, and quantum register writes.
// Depends on mlfq_pkg and the scheduler RTL only.
module mlfq_tick_scheduler_tb;

  // clock / reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // block ports, all driven from time zero
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  mlfq_pkg::in_beat_t            in_data  = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  mlfq_pkg::out_beat_t           out_data;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [mlfq_pkg::ADDR_W-1:0]   paddr   = '0;
  logic [mlfq_pkg::DATA_W-1:0]   pwdata  = '0;
  logic [mlfq_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  mlfq_tick_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // beats waiting to go out, and scheduler reports still owed by the block
  mlfq_pkg::in_beat_t  beats_to_send[$];
  mlfq_pkg::out_beat_t due_reports[$];
  int                  fail_count = 0;
  bit                  calm       = 1'b0;  // final stretch: no gaps, no stalls

  // ---------------------------------------------------------------------------
  // Scheduler shadow state. Slot stores are only read for busy slots, so their
  // contents after reset never matter.
  // ---------------------------------------------------------------------------
  logic [mlfq_pkg::QNT_W-1:0]   quanta [mlfq_pkg::LEVELS] =
    '{mlfq_pkg::QUANTUM0_RST, mlfq_pkg::QUANTUM1_RST, mlfq_pkg::QUANTUM2_RST};
  logic [mlfq_pkg::BURST_W-1:0] work_left  [mlfq_pkg::MAX_JOBS];
  logic [mlfq_pkg::ID_W-1:0]    slot_owner [mlfq_pkg::MAX_JOBS];
  bit                           slot_used  [mlfq_pkg::MAX_JOBS] = '{default: 1'b0};
  mlfq_pkg::slot_t              lvl_fifo   [mlfq_pkg::LEVELS][mlfq_pkg::MAX_JOBS];
  mlfq_pkg::slot_t              lvl_head   [mlfq_pkg::LEVELS] = '{default: '0};
  int                           lvl_count  [mlfq_pkg::LEVELS] = '{default: 0};
  mlfq_pkg::slot_t              run_slot    = '0;
  bit                           run_busy    = 1'b0;
  logic [mlfq_pkg::LVL_W-1:0]   run_lvl     = mlfq_pkg::LVL_TOP;
  logic [mlfq_pkg::QNT_W-1:0]   slice_ticks = '0;
  logic [mlfq_pkg::TIME_W-1:0]  now_ticks   = '0;

  // append a slot at the tail of one level
  function automatic void level_append(logic [mlfq_pkg::LVL_W-1:0] lvl, mlfq_pkg::slot_t s);
    int pos;
    pos = (int'(lvl_head[lvl]) + lvl_count[lvl]) % mlfq_pkg::MAX_JOBS;
    lvl_fifo[lvl][pos] = s;
    lvl_count[lvl]++;
  endfunction

  // one accepted beat -> the report the scheduler owes for it; updates shadow state
  function automatic mlfq_pkg::out_beat_t scheduler_step(mlfq_pkg::in_beat_t b);
    mlfq_pkg::out_beat_t        r;
    bit                         placed;
    logic [mlfq_pkg::QNT_W-1:0] q;
    r = '0;
    if (b.kind == mlfq_pkg::KIND_ARRIVAL) begin
      // arrivals never move time
      if (b.job_id == '0 || b.burst_length == '0) begin
        r.status = mlfq_pkg::ST_REJ_BAD;
      end else begin
        r.status = mlfq_pkg::ST_REJ_FULL;
        placed   = 1'b0;
        // lowest free slot wins; duplicate ids are fine
        for (int s = 0; s < mlfq_pkg::MAX_JOBS; s++) begin
          if (!placed && !slot_used[s]) begin
            placed        = 1'b1;
            slot_used[s]  = 1'b1;
            slot_owner[s] = b.job_id;
            work_left[s]  = b.burst_length;
            level_append(mlfq_pkg::LVL_TOP, mlfq_pkg::slot_t'(s));
            r.status      = mlfq_pkg::ST_ACCEPTED;
          end
        end
      end
    end else begin
      now_ticks++;
      // pick the head of the highest non-empty level only when nothing runs;
      // a running job keeps the CPU until its slice ends
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        if (!run_busy && lvl_count[l] > 0) begin
          run_slot    = lvl_fifo[l][lvl_head[l]];
          lvl_head[l] = lvl_head[l] + 1'b1;
          lvl_count[l]--;
          run_lvl     = mlfq_pkg::LVL_W'(l);
          run_busy    = 1'b1;
          slice_ticks = '0;
        end
      end
      if (!run_busy) begin
        r.status = mlfq_pkg::ST_IDLE;
      end else begin
        r.status    = mlfq_pkg::ST_RAN;
        r.ran_id    = slot_owner[run_slot];
        r.ran_level = run_lvl;
        if (work_left[run_slot] != '0) work_left[run_slot]--;
        slice_ticks++;
        q = (quanta[run_lvl] == '0) ? mlfq_pkg::QNT_W'(1) : quanta[run_lvl];
        if (work_left[run_slot] == '0) begin
          r.job_finished      = 1'b1;
          slot_used[run_slot] = 1'b0;
          run_busy            = 1'b0;
        end else if (slice_ticks >= q) begin
          // slice used up: demote, bottom level stays put
          level_append((run_lvl == mlfq_pkg::LVL_BOT) ? mlfq_pkg::LVL_BOT
                                                      : run_lvl + 1'b1, run_slot);
          run_busy = 1'b0;
        end
      end
    end
    r.tick_time = now_ticks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: fed from beats_to_send, with gaps of random length.
  // Payload holds while stalled; prediction happens on the accepting edge.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) due_reports.push_back(scheduler_step(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 19) - 1;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          in_data  <= beats_to_send[0];
          beats_to_send.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares each accepted beat against the oldest report owed,
  // and stalls the result channel in random bursts.
  // ---------------------------------------------------------------------------
  int                  stall_left = 0;
  mlfq_pkg::out_beat_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          $error("result beat with nothing owed: %p", out_data);
          fail_count++;
        end else begin
          want = due_reports[0];
          due_reports.delete(0);
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.ran_id !== want.ran_id) begin
            $error("ran_id: expected %0d, got %0d", want.ran_id, out_data.ran_id);
            fail_count++;
          end
          if (out_data.ran_level !== want.ran_level) begin
            $error("ran_level: expected %0d, got %0d", want.ran_level, out_data.ran_level);
            fail_count++;
          end
          if (out_data.job_finished !== want.job_finished) begin
            $error("job_finished: expected %0d, got %0d",
                   want.job_finished, out_data.job_finished);
            fail_count++;
          end
          if (out_data.tick_time !== want.tick_time) begin
            $error("tick_time: expected %0d, got %0d", want.tick_time, out_data.tick_time);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register port helpers (setup + access, completes on pready)
  // ---------------------------------------------------------------------------
  task automatic reg_write(int idx, logic [mlfq_pkg::QNT_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mlfq_pkg::ADDR_W'(idx * 4);
    pwdata  <= mlfq_pkg::DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // indexes past the last quantum are dropped by the block
    if (idx < mlfq_pkg::LEVELS) quanta[idx] = val;
  endtask

  task automatic reg_check(int idx);
    logic [mlfq_pkg::DATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= mlfq_pkg::ADDR_W'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[mlfq_pkg::QNT_W-1:0] !== quanta[idx]) begin
      $error("quantum_level%0d: expected %0d, got %0d", idx, quanta[idx],
             got[mlfq_pkg::QNT_W-1:0]);
      fail_count++;
    end
  endtask

  task automatic set_quanta(logic [mlfq_pkg::QNT_W-1:0] q0, logic [mlfq_pkg::QNT_W-1:0] q1,
                            logic [mlfq_pkg::QNT_W-1:0] q2);
    reg_write(mlfq_pkg::REG_QUANTUM0, q0);
    reg_write(mlfq_pkg::REG_QUANTUM1, q1);
    reg_write(mlfq_pkg::REG_QUANTUM2, q2);
    for (int i = 0; i < mlfq_pkg::LEVELS; i++) reg_check(i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void add_arrival(logic [mlfq_pkg::ID_W-1:0] id,
                                      logic [mlfq_pkg::BURST_W-1:0] burst);
    mlfq_pkg::in_beat_t b;
    b.kind         = mlfq_pkg::KIND_ARRIVAL;
    b.job_id       = id;
    b.burst_length = burst;
    beats_to_send.push_back(b);
  endfunction

  function automatic void add_tick();
    mlfq_pkg::in_beat_t b;
    b.kind         = mlfq_pkg::KIND_TICK;
    b.job_id       = mlfq_pkg::ID_W'($urandom);       // don't-care on ticks
    b.burst_length = mlfq_pkg::BURST_W'($urandom);
    beats_to_send.push_back(b);
  endfunction

  // mostly ticks so the queues drain and jobs walk down the levels; arrivals
  // are short so slots keep turning over, some bad ones mixed in
  function automatic void add_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        add_tick();
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       add_arrival('0, mlfq_pkg::BURST_W'($urandom_range(1, 65535)));
          1:       add_arrival(mlfq_pkg::ID_W'($urandom_range(1, 255)), '0);
          default: add_arrival('0, '0);
        endcase
      end else if ($urandom_range(0, 19) == 0) begin
        add_arrival(mlfq_pkg::ID_W'($urandom_range(1, 255)),
                    mlfq_pkg::BURST_W'($urandom_range(13, 400)));
      end else begin
        add_arrival(mlfq_pkg::ID_W'($urandom_range(1, 255)),
                    mlfq_pkg::BURST_W'($urandom_range(1, 12)));
      end
    end
  endfunction

  // wait until the block is idle: nothing queued and nothing in flight
  task automatic drain();
    while (beats_to_send.size() > 0 || in_valid || due_reports.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset quanta read back as 2/4/8
    for (int i = 0; i < mlfq_pkg::LEVELS; i++) reg_check(i);

    // directed: idle tick, bad arrivals, fill every slot (one job that never
    // finishes, a duplicate id, walking-one ids), one arrival too many, ticks
    add_tick();
    add_arrival('0, 16'd5);
    add_arrival(8'd9, '0);
    add_arrival('0, '0);
    add_arrival(8'd255, 16'hFFFF);
    add_arrival(8'd7, 16'd1);
    add_arrival(8'd7, 16'd2);
    for (int i = 0; i < 8; i++) begin
      add_arrival(mlfq_pkg::ID_W'(1 << i), mlfq_pkg::BURST_W'((i % 5) + 1));
    end
    add_arrival(8'h55, 16'd3);
    add_arrival(8'hAA, 16'd9);
    add_arrival(8'd200, 16'd1);
    add_arrival(8'd100, 16'd2);
    add_arrival(8'd50, 16'd7);
    add_arrival(8'd9, 16'd5);     // all slots busy here
    add_tick();
    add_tick();
    drain();

    // shortest slices: every tick that does not finish its job demotes it
    set_quanta(8'd1, 8'd1, 8'd1);
    add_random(120);
    drain();

    // longest slices
    set_quanta(8'd255, 8'd255, 8'd255);
    add_random(110);
    drain();

    // zero quanta behave as one; a write past the last register is dropped
    set_quanta('0, '0, '0);
    reg_write(3, 8'd5);
    for (int i = 0; i < mlfq_pkg::LEVELS; i++) reg_check(i);
    add_random(100);
    drain();

    // closing stretch at full rate, no gaps and no stalls
    set_quanta(8'd3, 8'd6, 8'd12);
    calm = 1'b1;
    add_random(150);

    while (beats_to_send.size() > 0 || in_valid) @(posedge clk);
    for (int i = 0; i < 5000 && due_reports.size() > 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_reports.size() > 0) begin
      $error("%0d result beats never arrived", due_reports.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
